@@ rtl/fpfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants of the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int PARTITIONS  = 4;
    localparam int SLOTS       = 16;
    localparam int SIZE_BITS   = 16;
    localparam int PART_BITS   = 2;
    localparam int NPART_BITS  = 3;
    localparam int POL_BITS    = 2;
    localparam int PID_BITS    = 16;
    localparam int STAT_BITS   = 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [STAT_BITS-1:0] ST_DONE       = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_NO_FIT     = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND  = 2'd3;

    localparam logic [POL_BITS-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_BITS-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_BITS-1:0] POL_WORST = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FIT_POLICY = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PARTS_USED = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PART0_SIZE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PART1_SIZE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PART2_SIZE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PART3_SIZE = 3'd5;

    localparam logic [NPART_BITS-1:0] NPART_RESET = NPART_BITS'(PARTITIONS);

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic [SIZE_BITS-1:0] result;
        logic                 ge;
        logic                 eq;
    } t_alu_res;

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_idx;
        logic [PID_BITS-1:0]  wr_pid;
        logic [PART_BITS-1:0] wr_part;
        logic [SIZE_BITS-1:0] wr_amount;
        logic                 clr_en;
        logic [SLOT_BITS-1:0] clr_idx;
        logic [SLOT_BITS-1:0] rd_idx;
    } t_ent_ctl;

    typedef struct packed {
        logic                 valid;
        logic [PID_BITS-1:0]  pid;
        logic [PART_BITS-1:0] part;
        logic [SIZE_BITS-1:0] amount;
        logic                 full;
        logic [SLOT_BITS-1:0] free_idx;
    } t_ent_sts;

endpackage

@@ rtl/fpfa_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_if
// Request, response and configuration channels of the allocator.
// ----------------------------------------------------------------------------
interface fpfa_req_if import fpfa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [PID_BITS-1:0]  proc_id;
    logic [SIZE_BITS-1:0] req_size;

    modport source (output valid, action, proc_id, req_size, input ready);
    modport sink   (input valid, action, proc_id, req_size, output ready);
endinterface

interface fpfa_rsp_if import fpfa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STAT_BITS-1:0] status;
    logic [PART_BITS-1:0] part_index;
    logic [SIZE_BITS-1:0] part_free;

    modport source (output valid, status, part_index, part_free, input ready);
    modport sink   (input valid, status, part_index, part_free, output ready);
endinterface

interface fpfa_cfg_if import fpfa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [SIZE_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/fpfa_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_alu
// Shared adder: wrapping add, or saturating subtract with compare flags.
// ----------------------------------------------------------------------------
module fpfa_alu import fpfa_pkg::*; (
    input  t_alu_op              i_op,
    input  logic [SIZE_BITS-1:0] i_a,
    input  logic [SIZE_BITS-1:0] i_b,
    output t_alu_res             o_res
);

    logic                 w_sub;
    logic [SIZE_BITS-1:0] w_b;
    logic [SIZE_BITS:0]   w_sum;
    logic                 w_carry;

    assign w_sub   = (i_op == ALU_SUB);
    assign w_b     = w_sub ? ~i_b : i_b;
    assign w_sum   = {1'b0, i_a} + {1'b0, w_b} + {{SIZE_BITS{1'b0}}, w_sub};
    assign w_carry = w_sum[SIZE_BITS];

    // on subtract, carry out means a >= b
    always_comb begin
        o_res.ge = w_carry;
        o_res.eq = w_carry && (w_sum[SIZE_BITS-1:0] == '0);
        if (w_sub && !w_carry) begin
            o_res.result = '0;
        end else begin
            o_res.result = w_sum[SIZE_BITS-1:0];
        end
    end

endmodule

@@ rtl/fpfa_entry_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_entry_table
// Grant records: valid bits, owner id, partition and granted amount.
// ----------------------------------------------------------------------------
module fpfa_entry_table import fpfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ent_ctl i_ctl,
    output t_ent_sts o_sts
);

    logic [SLOTS-1:0]     r_valid;
    logic [PID_BITS-1:0]  r_pid    [SLOTS];
    logic [PART_BITS-1:0] r_part   [SLOTS];
    logic [SIZE_BITS-1:0] r_amount [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_idx] <= 1'b1;
            end
            if (i_ctl.clr_en) begin
                r_valid[i_ctl.clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_pid[i_ctl.wr_idx]    <= i_ctl.wr_pid;
            r_part[i_ctl.wr_idx]   <= i_ctl.wr_part;
            r_amount[i_ctl.wr_idx] <= i_ctl.wr_amount;
        end
    end

    // lowest free entry
    always_comb begin
        o_sts.free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_sts.free_idx = SLOT_BITS'(i);
            end
        end
        o_sts.full   = &r_valid;
        o_sts.valid  = r_valid[i_ctl.rd_idx];
        o_sts.pid    = r_pid[i_ctl.rd_idx];
        o_sts.part   = r_part[i_ctl.rd_idx];
        o_sts.amount = r_amount[i_ctl.rd_idx];
    end

endmodule

@@ rtl/fixed_partition_fit_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition allocator with first, best and worst fit.
// ----------------------------------------------------------------------------
// One request is handled at a time; every request beat gives one response
// beat. A single adder/comparator is stepped by the sequencer. An allocate
// visits each partition considered in a free-space and a size-check state,
// plus a compare state when best or worst fit compares an adequate partition
// against the current pick; first fit stops at the first match. The table
// check follows. A release walks all 16 entries one per cycle comparing ids,
// then the hit check. A failed check, or an allocate with no partition in
// use, goes straight to the output state; else the used-space add or
// subtract, the free-space update and the output state follow. The sequencer
// then returns to idle for the next request. A request may be accepted while
// the previous response is still waiting; the finished response then holds
// until the output register frees. Config writes are always taken and are
// meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator import fpfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpfa_req_if.sink    i_req,
    fpfa_rsp_if.source  o_rsp,
    fpfa_cfg_if.sink    i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_FREE,
        S_A_FIT,
        S_A_CMP,
        S_A_CHECK,
        S_A_ADD,
        S_UPD_FREE,
        S_R_SCAN,
        S_R_CHECK,
        S_R_SUB,
        S_OUT
    } t_state;

    t_state r_state;

    logic [POL_BITS-1:0]   r_policy;
    logic [NPART_BITS-1:0] r_nparts_cfg;
    logic [SIZE_BITS-1:0]  r_part_size [PARTITIONS];
    logic [SIZE_BITS-1:0]  r_part_used [PARTITIONS];

    logic [PID_BITS-1:0]   r_pid;
    logic [SIZE_BITS-1:0]  r_size;
    logic [PART_BITS-1:0]  r_scan_p;
    logic [SLOT_BITS-1:0]  r_scan_e;
    logic [SIZE_BITS-1:0]  r_free;
    logic                  r_pick_valid;
    logic [SIZE_BITS-1:0]  r_pick_free;
    logic [PART_BITS-1:0]  r_part;
    logic                  r_hit_valid;
    logic [SLOT_BITS-1:0]  r_hit;
    logic [STAT_BITS-1:0]  r_status;
    logic [SIZE_BITS-1:0]  r_res_free;

    logic                  r_out_valid;
    logic [STAT_BITS-1:0]  r_out_status;
    logic [PART_BITS-1:0]  r_out_part;
    logic [SIZE_BITS-1:0]  r_out_free;

    logic [NPART_BITS-1:0] w_nparts;
    logic                  w_last_part;
    logic                  w_last_entry;
    logic [PART_BITS-1:0]  w_pi;
    t_alu_op               w_op;
    logic [SIZE_BITS-1:0]  w_a;
    logic [SIZE_BITS-1:0]  w_b;
    t_alu_res              w_alu;
    t_ent_ctl              w_ent_ctl;
    t_ent_sts              w_ent;
    logic                  w_take;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.part_index = r_out_part;
    assign o_rsp.part_free  = r_out_free;

    // counts above the partition total clamp to it
    assign w_nparts = (r_nparts_cfg > NPART_BITS'(PARTITIONS)) ?
                      NPART_BITS'(PARTITIONS) : r_nparts_cfg;
    assign w_last_part  = (({1'b0, r_scan_p} + NPART_BITS'(1)) == w_nparts);
    assign w_last_entry = (r_scan_e == SLOT_BITS'(SLOTS - 1));
    assign w_pi         = (r_state == S_A_FREE) ? r_scan_p : r_part;

    // operand select for the shared unit
    always_comb begin
        w_op = ALU_SUB;
        w_a  = '0;
        w_b  = '0;
        case (r_state)
            S_A_FREE, S_UPD_FREE: begin
                w_a = r_part_size[w_pi];
                w_b = r_part_used[w_pi];
            end
            S_A_FIT: begin
                w_a = r_free;
                w_b = r_size;
            end
            S_A_CMP: begin
                w_a = r_free;
                w_b = r_pick_free;
            end
            S_A_ADD: begin
                w_op = ALU_ADD;
                w_a  = r_part_used[w_pi];
                w_b  = r_size;
            end
            S_R_SCAN: begin
                w_a = r_pid;
                w_b = w_ent.pid;
            end
            S_R_SUB: begin
                w_a = r_part_used[w_pi];
                w_b = w_ent.amount;
            end
            default: begin
                w_op = ALU_SUB;
            end
        endcase
    end

    fpfa_alu u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_alu)
    );

    always_comb begin
        w_ent_ctl.wr_en     = (r_state == S_A_CHECK) && r_pick_valid && !w_ent.full;
        w_ent_ctl.wr_idx    = w_ent.free_idx;
        w_ent_ctl.wr_pid    = r_pid;
        w_ent_ctl.wr_part   = r_part;
        w_ent_ctl.wr_amount = r_size;
        w_ent_ctl.clr_en    = (r_state == S_R_SUB);
        w_ent_ctl.clr_idx   = r_hit;
        w_ent_ctl.rd_idx    = (r_state == S_R_SCAN) ? r_scan_e : r_hit;
    end

    fpfa_entry_table u_entries (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ent_ctl),
        .o_sts   (w_ent)
    );

    // best fit: strictly smaller wins; worst fit: strictly larger wins
    assign w_take = (r_policy == POL_BEST) ? !w_alu.ge : (w_alu.ge && !w_alu.eq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POL_FIRST;
            r_nparts_cfg <= NPART_RESET;
            for (int i = 0; i < PARTITIONS; i++) begin
                r_part_size[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FIT_POLICY: r_policy       <= i_cfg.data[POL_BITS-1:0];
                REG_PARTS_USED: r_nparts_cfg   <= i_cfg.data[NPART_BITS-1:0];
                REG_PART0_SIZE: r_part_size[0] <= i_cfg.data;
                REG_PART1_SIZE: r_part_size[1] <= i_cfg.data;
                REG_PART2_SIZE: r_part_size[2] <= i_cfg.data;
                REG_PART3_SIZE: r_part_size[3] <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_pick_valid <= 1'b0;
            r_hit_valid  <= 1'b0;
            for (int i = 0; i < PARTITIONS; i++) begin
                r_part_used[i] <= '0;
            end
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_pid        <= i_req.proc_id;
                        r_size       <= i_req.req_size;
                        r_scan_p     <= '0;
                        r_scan_e     <= '0;
                        r_pick_valid <= 1'b0;
                        r_pick_free  <= '0;
                        r_hit_valid  <= 1'b0;
                        r_part       <= '0;
                        r_res_free   <= '0;
                        if (i_req.action == ACT_RELEASE) begin
                            r_state <= S_R_SCAN;
                        end else if (w_nparts == '0) begin
                            r_status <= ST_NO_FIT;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_A_FREE;
                        end
                    end
                end
                S_A_FREE: begin
                    r_free  <= w_alu.result;
                    r_state <= S_A_FIT;
                end
                S_A_FIT: begin
                    if (!w_alu.ge) begin
                        r_scan_p <= r_scan_p + PART_BITS'(1);
                        r_state  <= w_last_part ? S_A_CHECK : S_A_FREE;
                    end else begin
                        case (r_policy)
                            POL_BEST: begin
                                if (!r_pick_valid) begin
                                    r_pick_valid <= 1'b1;
                                    r_part       <= r_scan_p;
                                    r_pick_free  <= r_free;
                                    r_scan_p     <= r_scan_p + PART_BITS'(1);
                                    r_state      <= w_last_part ? S_A_CHECK : S_A_FREE;
                                end else begin
                                    r_state <= S_A_CMP;
                                end
                            end
                            POL_WORST: begin
                                r_state <= S_A_CMP;
                            end
                            default: begin
                                r_pick_valid <= 1'b1;
                                r_part       <= r_scan_p;
                                r_state      <= S_A_CHECK;
                            end
                        endcase
                    end
                end
                S_A_CMP: begin
                    if (w_take) begin
                        r_pick_valid <= 1'b1;
                        r_part       <= r_scan_p;
                        r_pick_free  <= r_free;
                    end
                    r_scan_p <= r_scan_p + PART_BITS'(1);
                    r_state  <= w_last_part ? S_A_CHECK : S_A_FREE;
                end
                S_A_CHECK: begin
                    if (!r_pick_valid) begin
                        r_status <= ST_NO_FIT;
                        r_part   <= '0;
                        r_state  <= S_OUT;
                    end else if (w_ent.full) begin
                        r_status <= ST_TABLE_FULL;
                        r_part   <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_A_ADD;
                    end
                end
                S_A_ADD: begin
                    r_part_used[w_pi] <= w_alu.result;
                    r_state           <= S_UPD_FREE;
                end
                S_UPD_FREE: begin
                    r_res_free <= w_alu.result;
                    r_status   <= ST_DONE;
                    r_state    <= S_OUT;
                end
                S_R_SCAN: begin
                    if (w_ent.valid && w_alu.eq &&
                        (!r_hit_valid || (w_ent.part < r_part))) begin
                        r_hit_valid <= 1'b1;
                        r_hit       <= r_scan_e;
                        r_part      <= w_ent.part;
                    end
                    r_scan_e <= r_scan_e + SLOT_BITS'(1);
                    if (w_last_entry) begin
                        r_state <= S_R_CHECK;
                    end
                end
                S_R_CHECK: begin
                    if (!r_hit_valid) begin
                        r_status <= ST_NOT_FOUND;
                        r_part   <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_R_SUB;
                    end
                end
                S_R_SUB: begin
                    r_part_used[w_pi] <= w_alu.result;
                    r_state           <= S_UPD_FREE;
                end
                S_OUT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_part   <= r_part;
                        r_out_free   <= r_res_free;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed partition fit allocator.
// A queue of pending requests feeds a clocked driver. Each request beat is
// run through a local model of the partitions and the entry table, and the
// expected response is queued. A clocked monitor compares every response beat
// field by field, in order. A short directed pass comes first, then random
// phases, each with its own register settings. Both sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb;
    import fpfa_pkg::*;

    localparam logic [POL_BITS-1:0]     POL_SPARE    = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic                 action;
        logic [PID_BITS-1:0]  pid;
        logic [SIZE_BITS-1:0] size;
        bit                   pick_live;
        bit                   hold;
    } t_request;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [PART_BITS-1:0] part;
        logic [SIZE_BITS-1:0] room;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpfa_req_if req ();
    fpfa_rsp_if rsp ();
    fpfa_cfg_if cfg ();

    fixed_partition_fit_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .i_cfg   (cfg)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // allocator model state
    logic [POL_BITS-1:0]   pol_q;
    logic [NPART_BITS-1:0] nparts_q;
    logic [SIZE_BITS-1:0]  cap_q  [PARTITIONS];
    logic [SIZE_BITS-1:0]  used_q [PARTITIONS];
    bit                    ent_live [SLOTS];
    logic [PID_BITS-1:0]   ent_pid  [SLOTS];
    logic [PART_BITS-1:0]  ent_part [SLOTS];
    logic [SIZE_BITS-1:0]  ent_amt  [SLOTS];

    t_request requests_to_send[$];
    t_answer  answers_due[$];

    t_request in_flight;
    bit       send_calm, take_calm;
    int       gap_left, stall_left, outstanding;
    int       mismatches, n_answers, n_alloc, n_release, n_writes, quiet;
    int       status_seen [4];

    function automatic logic [SIZE_BITS-1:0] room_of(int p);
        return (cap_q[p] >= used_q[p]) ? cap_q[p] - used_q[p] : '0;
    endfunction

    function automatic void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
        case (idx)
            REG_FIT_POLICY: pol_q = val[POL_BITS-1:0];
            REG_PARTS_USED: nparts_q = val[NPART_BITS-1:0];
            REG_PART0_SIZE, REG_PART1_SIZE, REG_PART2_SIZE, REG_PART3_SIZE: begin
                cap_q[idx - REG_PART0_SIZE] = val;
            end
            default: ;
        endcase
    endfunction

    function automatic t_answer apply_request(t_request it);
        t_answer              r;
        int                   n, pick, slot, hit;
        logic [SIZE_BITS-1:0] pick_room, f;
        r = '{status: ST_DONE, part: '0, room: '0};
        if (it.action == ACT_ALLOC) begin
            n = (nparts_q > PARTITIONS) ? PARTITIONS : int'(nparts_q);
            pick = -1;
            pick_room = '0;
            for (int p = 0; p < n; p++) begin
                f = room_of(p);
                if (f >= it.size) begin
                    if (pol_q == POL_BEST) begin
                        if (pick < 0 || f < pick_room) begin
                            pick = p;
                            pick_room = f;
                        end
                    end else if (pol_q == POL_WORST) begin
                        if (f > pick_room) begin
                            pick = p;
                            pick_room = f;
                        end
                    end else if (pick < 0) begin
                        pick = p;
                    end
                end
            end
            slot = -1;
            for (int e = SLOTS - 1; e >= 0; e--) begin
                if (!ent_live[e]) slot = e;
            end
            if (pick < 0) begin
                r.status = ST_NO_FIT;
            end else if (slot < 0) begin
                r.status = ST_TABLE_FULL;
            end else begin
                used_q[pick]   = used_q[pick] + it.size;
                ent_live[slot] = 1'b1;
                ent_pid[slot]  = it.pid;
                ent_part[slot] = pick[PART_BITS-1:0];
                ent_amt[slot]  = it.size;
                r.part = pick[PART_BITS-1:0];
                r.room = room_of(pick);
            end
        end else begin
            hit = -1;
            for (int e = 0; e < SLOTS; e++) begin
                if (ent_live[e] && ent_pid[e] == it.pid) begin
                    if (hit < 0 || ent_part[e] < ent_part[hit]) hit = e;
                end
            end
            if (hit < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                n = int'(ent_part[hit]);
                used_q[n] = (used_q[n] >= ent_amt[hit]) ? used_q[n] - ent_amt[hit] : '0;
                ent_live[hit] = 1'b0;
                r.part = ent_part[hit];
                r.room = room_of(n);
            end
        end
        return r;
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // request driver
    always @(posedge i_clk) begin : req_driver
        t_request nxt;
        t_answer  ans;
        int       live_slots[$];
        bit       present;
        if (!i_rst_n) begin
            req.valid    <= 1'b0;
            req.action   <= ACT_ALLOC;
            req.proc_id  <= '0;
            req.req_size <= '0;
            gap_left    = 0;
            outstanding = 0;
        end else begin
            present = req.valid;
            if (req.valid && req.ready) begin
                ans = apply_request(in_flight);
                answers_due = {answers_due, ans};
                status_seen[ans.status]++;
                if (in_flight.action == ACT_ALLOC) n_alloc++;
                else n_release++;
                outstanding++;
                present = 1'b0;
                if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
                gap_left = send_calm ? 0 : $urandom_range(0, 19);
            end
            if (rsp.valid && rsp.ready) outstanding--;
            if (!present) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (requests_to_send.size() > 0 &&
                             (!requests_to_send[0].hold || outstanding == 0)) begin
                    nxt = requests_to_send.pop_front();
                    if (nxt.pick_live) begin
                        live_slots.delete();
                        for (int e = 0; e < SLOTS; e++) begin
                            if (ent_live[e]) live_slots = {live_slots, e};
                        end
                        if (live_slots.size() > 0) begin
                            nxt.pid = ent_pid[live_slots[$urandom_range(0, live_slots.size() - 1)]];
                        end
                    end
                    in_flight = nxt;
                    req.action   <= nxt.action;
                    req.proc_id  <= nxt.pid;
                    req.req_size <= nxt.size;
                    present = 1'b1;
                end
            end
            req.valid <= present;
        end
    end

    // response monitor
    always @(posedge i_clk) begin : rsp_monitor
        t_answer want;
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                n_answers++;
                if (answers_due.size() == 0) begin
                    report($sformatf("beat %0d: response with nothing pending", n_answers));
                end else begin
                    want = answers_due.pop_front();
                    if (rsp.status !== want.status)
                        report($sformatf("beat %0d: status %0d, want %0d",
                                         n_answers, rsp.status, want.status));
                    if (rsp.part_index !== want.part)
                        report($sformatf("beat %0d: part_index %0d, want %0d",
                                         n_answers, rsp.part_index, want.part));
                    if (rsp.part_free !== want.room)
                        report($sformatf("beat %0d: part_free %0d, want %0d",
                                         n_answers, rsp.part_free, want.room));
                end
                if ($urandom_range(0, 19) == 0) take_calm = !take_calm;
                stall_left = take_calm ? 0 : $urandom_range(0, 19);
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", quiet);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic queue_request(logic action, logic [PID_BITS-1:0] pid,
                                 logic [SIZE_BITS-1:0] size, bit pick_live = 1'b0,
                                 bit hold = 1'b0);
        t_request it;
        it = '{action: action, pid: pid, size: size, pick_live: pick_live, hold: hold};
        requests_to_send = {requests_to_send, it};
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (requests_to_send.size() != 0 || req.valid || answers_due.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        set_reg(idx, val);
        n_writes++;
    endtask

    task automatic write_all(logic [POL_BITS-1:0] pol, logic [NPART_BITS-1:0] np,
                             logic [SIZE_BITS-1:0] c0, logic [SIZE_BITS-1:0] c1,
                             logic [SIZE_BITS-1:0] c2, logic [SIZE_BITS-1:0] c3);
        write_reg(REG_FIT_POLICY, pol);
        write_reg(REG_PARTS_USED, np);
        write_reg(REG_PART0_SIZE, c0);
        write_reg(REG_PART1_SIZE, c1);
        write_reg(REG_PART2_SIZE, c2);
        write_reg(REG_PART3_SIZE, c3);
        @(negedge i_clk);
    endtask

    task automatic random_phase(int n_items, int alloc_pct, bit fill, bit drain_mid);
        logic [POL_BITS-1:0]   pol;
        logic [NPART_BITS-1:0] np;
        logic [SIZE_BITS-1:0]  caps [PARTITIONS];
        logic [SIZE_BITS-1:0]  sz;
        int                    size_top, roll;
        wait_idle();
        pol  = POL_BITS'($urandom_range(0, 3));
        roll = $urandom_range(0, 9);
        np   = (roll == 0) ? 3'd0 : (roll == 1) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(1, 4));
        foreach (caps[p]) begin
            roll = $urandom_range(0, 9);
            caps[p] = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF :
                      (roll == 2) ? 16'($urandom) : 16'($urandom_range(1, 3000));
        end
        size_top = $urandom_range(8, 1000);
        if (fill) begin
            np = NPART_RESET;
            foreach (caps[p]) caps[p] = 16'hFFFF;
        end
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
        write_all(pol, np, caps[0], caps[1], caps[2], caps[3]);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                roll = $urandom_range(0, 19);
                sz = (roll == 0) ? 16'd0 : (roll == 1) ? 16'($urandom) :
                     (roll == 2) ? 16'hFFFF : 16'($urandom_range(1, size_top));
                queue_request(ACT_ALLOC, 16'($urandom), sz, $urandom_range(0, 9) == 0,
                              drain_mid && i == n_items / 2);
            end else begin
                queue_request(ACT_RELEASE, 16'($urandom), 16'($urandom),
                              $urandom_range(0, 9) != 0, drain_mid && i == n_items / 2);
            end
        end
    endtask

    initial begin : stimulus
        req.valid    = 1'b0;
        req.action   = ACT_ALLOC;
        req.proc_id  = '0;
        req.req_size = '0;
        rsp.ready    = 1'b0;
        cfg.valid    = 1'b0;
        cfg.index    = REG_FIT_POLICY;
        cfg.data     = '0;
        pol_q    = POL_FIRST;
        nparts_q = NPART_RESET;
        foreach (cap_q[p]) begin
            cap_q[p]  = '0;
            used_q[p] = '0;
        end
        foreach (ent_live[e]) ent_live[e] = 1'b0;
        foreach (status_seen[s]) status_seen[s] = 0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero capacities, a zero-size request still fits
        queue_request(ACT_ALLOC, 16'h0001, 16'd0);
        queue_request(ACT_ALLOC, 16'h0002, 16'd1);
        queue_request(ACT_RELEASE, 16'h1234, 16'd0);
        queue_request(ACT_RELEASE, 16'h0001, 16'hFFFF);

        // first fit, reused live id, release picks lowest partition
        wait_idle();
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h5A5A);
        write_all(POL_FIRST, NPART_RESET, 16'd100, 16'd200, 16'd50, 16'hFFFF);
        queue_request(ACT_ALLOC, 16'hFFFF, 16'hFFFF);
        queue_request(ACT_ALLOC, 16'd10, 16'd60);
        queue_request(ACT_ALLOC, 16'd10, 16'd60);
        queue_request(ACT_RELEASE, 16'd10, 16'd0);
        queue_request(ACT_RELEASE, 16'hFFFF, 16'd0);

        wait_idle();
        write_all(POL_BEST, NPART_RESET, 16'd100, 16'd200, 16'd50, 16'hFFFF);
        queue_request(ACT_ALLOC, 16'd0, 16'd40);
        queue_request(ACT_ALLOC, 16'd21, 16'd0);

        wait_idle();
        write_all(POL_WORST, NPART_RESET, 16'd100, 16'd200, 16'd50, 16'hFFFF);
        queue_request(ACT_ALLOC, 16'd22, 16'd1);
        queue_request(ACT_ALLOC, 16'd23, 16'd0);

        // spare policy code, no partitions: release still finds entries
        wait_idle();
        write_all(POL_SPARE, 3'd0, 16'd100, 16'd200, 16'd50, 16'hFFFF);
        queue_request(ACT_ALLOC, 16'd24, 16'd1);
        queue_request(ACT_RELEASE, 16'd10, 16'd0);

        // count above range, worst fit with no free space anywhere
        wait_idle();
        write_all(POL_WORST, 3'd7, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_request(ACT_ALLOC, 16'd25, 16'd0);
        queue_request(ACT_RELEASE, 16'd0, 16'd0);

        random_phase(40, 90, 1'b1, 1'b0);
        for (int ph = 0; ph < 9; ph++) begin
            random_phase(50, $urandom_range(35, 75), 1'b0, ph % 3 == 1);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d allocate and %0d release beats, %0d register writes",
                 n_alloc, n_release, n_writes);
        $display("outcomes: done %0d, no fit %0d, table full %0d, id not found %0d",
                 status_seen[ST_DONE], status_seen[ST_NO_FIT],
                 status_seen[ST_TABLE_FULL], status_seen[ST_NOT_FOUND]);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/fpfa_pkg.sv
rtl/fpfa_if.sv
rtl/fpfa_alu.sv
rtl/fpfa_entry_table.sv
rtl/fixed_partition_fit_allocator.sv
sim/tb.sv
